>>> rtl/bbf_pkg.sv
// Shared types and codes for the bounded byte FIFO.
package bbf_pkg;

  localparam int CNT_W  = 7;
  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int TOT_W  = 64;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  typedef enum logic [2:0] {
    K_NONE,
    K_WRITE,
    K_END,
    K_PEEK,
    K_POP,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  length;
  } cmd_t;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              write_accepted;
    logic [CNT_W-1:0]  buffered_count;
    logic [CNT_W-1:0]  remaining_space;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
    logic              input_closed;
    logic              end_of_stream;
  } res_t;

endpackage

>>> rtl/bounded_byte_stream_fifo.sv
// Top level of the bounded byte FIFO: front-end command queue plus execution back end.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   write byte, end input, peek, pop or read, with its byte and length.
//   Result channel (out_valid / out_stall) returns one status transfer per
//   operation, or one transfer per delivered byte for a peek or read of
//   n > 0 bytes; out_last marks the final transfer of each operation.
//   cfg_valid / cfg_ready writes the capacity register (ready is always high);
//   write it only while the block is idle.
// Pipeline and throughput:
//   A single-result operation passes a queue slot, then the result register; a peek
//   or read passes a queue slot and the burst state, and each byte the RAM read
//   register and then the result register. While out_stall is low, single-result
//   ops sustain one per cycle; a burst holds the back end, one RAM byte per cycle.
// Reset (rst_n low, synchronous): buffer empty, input open, totals zero,
//   capacity 64. Stored bytes are not cleared.
// Stall: a stalled result holds; the two-entry command queue keeps taking
//   input until it fills, then in_stall rises.
module bounded_byte_stream_fifo #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   in_operation,
  input  logic [7:0]   in_data_byte,
  input  logic [6:0]   in_length,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_byte_valid,
  output logic [7:0]   out_byte,
  output logic         out_last,
  output logic         out_write_accepted,
  output logic [6:0]   out_buffered_count,
  output logic [6:0]   out_remaining_space,
  output logic [63:0]  out_total_written,
  output logic [63:0]  out_total_read,
  output logic         out_input_closed,
  output logic         out_end_of_stream,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_capacity
);

  logic          q_valid;
  logic          q_pop;
  bbf_pkg::cmd_t q_cmd;
  bbf_pkg::res_t res;

  assign cfg_ready = 1'b1;

  bbf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_length    (in_length),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  bbf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_capacity),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .res_valid    (out_valid),
    .res          (res),
    .res_stall    (out_stall)
  );

  assign out_byte_valid      = res.byte_valid;
  assign out_byte            = res.out_byte;
  assign out_last            = res.last;
  assign out_write_accepted  = res.write_accepted;
  assign out_buffered_count  = res.buffered_count;
  assign out_remaining_space = res.remaining_space;
  assign out_total_written   = res.total_written;
  assign out_total_read      = res.total_read;
  assign out_input_closed    = res.input_closed;
  assign out_end_of_stream   = res.end_of_stream;

endmodule

>>> rtl/bbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bbf_front.sv
// Front end: accepts input items, decodes the operation, queues commands.
module bbf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bbf_pkg::OP_W-1:0]     in_operation,
  input  logic [bbf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [bbf_pkg::CNT_W-1:0]    in_length,
  output logic                         q_valid,
  output bbf_pkg::cmd_t                q_cmd,
  input  logic                         q_pop
);

  bbf_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  bbf_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.data   = in_data_byte;
    cmd_in.length = in_length;
    unique case (in_operation)
      bbf_pkg::OP_WRITE: cmd_in.kind = bbf_pkg::K_WRITE;
      bbf_pkg::OP_END:   cmd_in.kind = bbf_pkg::K_END;
      bbf_pkg::OP_PEEK:  cmd_in.kind = bbf_pkg::K_PEEK;
      bbf_pkg::OP_POP:   cmd_in.kind = bbf_pkg::K_POP;
      bbf_pkg::OP_READ:  cmd_in.kind = bbf_pkg::K_READ;
      default:           cmd_in.kind = bbf_pkg::K_NONE;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> rtl/bbf_back.sv
// Back end: owns the FIFO state, executes commands and drives the result register.
module bbf_back #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bbf_pkg::CNT_W-1:0]  cfg_capacity,
  input  logic                       q_valid,
  input  bbf_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       res_valid,
  output bbf_pkg::res_t              res,
  input  logic                       res_stall
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;
  localparam int CW = bbf_pkg::CNT_W;
  localparam int TW = bbf_pkg::TOT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BURST = 2'b10
  } state_t;

  state_t         st_r, st_nxt;
  logic [CW-1:0]  cap_r, cap_eff;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  held_r, held_nxt;
  logic           closed_r, closed_nxt;
  logic [TW-1:0]  wtot_r, wtot_nxt;
  logic [TW-1:0]  rtot_r, rtot_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic           p_r, p_nxt;
  logic           p_last_r, p_last_nxt;
  logic           o_valid_r, o_valid_nxt;
  bbf_pkg::res_t  o_res_r, o_res_nxt;
  logic           o_load;

  logic           o_free, cmd_go, burst_cmd, wr_ok, p_take, issue;
  logic [CW-1:0]  n;
  logic [AW-1:0]  tail;
  logic           mem_we;
  logic [7:0]     rdata;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] d;
    d = s - SW'(DEPTH);
    return (s >= SW'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  function automatic bbf_pkg::res_t status(input logic [CW-1:0] held,
                                           input logic          closed,
                                           input logic [TW-1:0] wt,
                                           input logic [TW-1:0] rt,
                                           input logic [CW-1:0] cap);
    bbf_pkg::res_t r;
    r                 = '0;
    r.buffered_count  = held;
    r.remaining_space = (cap > held) ? cap - held : '0;
    r.total_written   = wt;
    r.total_read      = rt;
    r.input_closed    = closed;
    r.end_of_stream   = closed && (held == '0);
    return r;
  endfunction

  assign cap_eff   = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
  assign o_free    = !o_valid_r || !res_stall;
  assign n         = (q_cmd.length < held_r) ? q_cmd.length : held_r;
  assign burst_cmd = (q_cmd.kind == bbf_pkg::K_PEEK || q_cmd.kind == bbf_pkg::K_READ)
                     && (n != '0);
  assign cmd_go    = q_valid && (st_r == S_IDLE) && (o_free || burst_cmd);
  assign q_pop     = cmd_go;
  assign wr_ok     = !closed_r && (held_r < cap_eff);
  assign tail      = wrap(SW'(head_r) + held_r[SW-1:0]);
  assign mem_we    = cmd_go && (q_cmd.kind == bbf_pkg::K_WRITE) && wr_ok;
  assign p_take    = p_r && o_free;
  assign issue     = (st_r == S_BURST) && (rem_r != '0) && (!p_r || p_take);

  always_comb begin
    st_nxt      = st_r;
    head_nxt    = head_r;
    held_nxt    = held_r;
    closed_nxt  = closed_r;
    wtot_nxt    = wtot_r;
    rtot_nxt    = rtot_r;
    rd_ptr_nxt  = rd_ptr_r;
    rem_nxt     = rem_r;
    p_nxt       = p_r;
    p_last_nxt  = p_last_r;
    o_load      = 1'b0;
    o_res_nxt   = o_res_r;

    unique case (st_r)
      S_IDLE: begin
        if (cmd_go) begin
          case (q_cmd.kind)
            bbf_pkg::K_WRITE: begin
              if (wr_ok) begin
                held_nxt = held_r + CW'(1);
                wtot_nxt = wtot_r + TW'(1);
              end
            end
            bbf_pkg::K_END: closed_nxt = 1'b1;
            default: ;
          endcase
          // pop and read commit their removal up front; status shows the end state
          if (q_cmd.kind == bbf_pkg::K_POP || q_cmd.kind == bbf_pkg::K_READ) begin
            head_nxt = wrap(SW'(head_r) + n[SW-1:0]);
            held_nxt = held_r - n;
            rtot_nxt = rtot_r + TW'(n);
          end
          if (burst_cmd) begin
            st_nxt     = S_BURST;
            rd_ptr_nxt = head_r;
            rem_nxt    = n;
          end else begin
            o_load                   = 1'b1;
            o_res_nxt                = status(held_nxt, closed_nxt, wtot_nxt, rtot_nxt,
                                              cap_eff);
            o_res_nxt.last           = 1'b1;
            o_res_nxt.write_accepted = (q_cmd.kind == bbf_pkg::K_WRITE) && wr_ok;
          end
        end
      end
      S_BURST: begin
        if (p_take) begin
          o_load               = 1'b1;
          o_res_nxt            = status(held_r, closed_r, wtot_r, rtot_r, cap_eff);
          o_res_nxt.byte_valid = 1'b1;
          o_res_nxt.out_byte   = rdata;
          o_res_nxt.last       = p_last_r;
          p_nxt                = 1'b0;
          if (p_last_r) begin
            st_nxt = S_IDLE;
          end
        end
        if (issue) begin
          rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
          rem_nxt    = rem_r - CW'(1);
          p_nxt      = 1'b1;
          p_last_nxt = (rem_r == CW'(1));
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (o_load) begin
      o_valid_nxt = 1'b1;
    end else if (!res_stall) begin
      o_valid_nxt = 1'b0;
    end else begin
      o_valid_nxt = o_valid_r;
    end
  end

  bbf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail),
    .wdata (q_cmd.data),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cap_r     <= CW'(64);
      head_r    <= '0;
      held_r    <= '0;
      closed_r  <= 1'b0;
      wtot_r    <= '0;
      rtot_r    <= '0;
      rem_r     <= '0;
      p_r       <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      head_r    <= head_nxt;
      held_r    <= held_nxt;
      closed_r  <= closed_nxt;
      wtot_r    <= wtot_nxt;
      rtot_r    <= rtot_nxt;
      rem_r     <= rem_nxt;
      p_r       <= p_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    p_last_r <= p_last_nxt;
    o_res_r  <= o_res_nxt;
  end

  assign res_valid = o_valid_r;
  assign res       = o_res_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= DEPTH_C)
    else $error("held count above depth");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_IDLE |-> !p_r)
    else $error("read data pending outside a burst");

  a_last_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (p_take && p_last_r) |-> rem_r == '0)
    else $error("last byte sent with reads outstanding");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> held_r == $past(held_r) + CW'(1))
    else $error("stored write did not grow the count");

endmodule

>>> tb/sv/tb_bounded_byte_stream_fifo.sv
// Self-checking testbench for the bounded byte FIFO: directed and random traffic.
module tb_bounded_byte_stream_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [bbf_pkg::OP_W-1:0] OP_LAST_CODE = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [7:0]  in_data_byte = '0;
  logic [6:0]  in_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_byte_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_write_accepted;
  logic [6:0]  out_buffered_count;
  logic [6:0]  out_remaining_space;
  logic [63:0] out_total_written;
  logic [63:0] out_total_read;
  logic        out_input_closed;
  logic        out_end_of_stream;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_capacity = '0;

  bounded_byte_stream_fifo #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_data_byte(in_data_byte),
    .in_length(in_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte_valid(out_byte_valid),
    .out_byte(out_byte),
    .out_last(out_last),
    .out_write_accepted(out_write_accepted),
    .out_buffered_count(out_buffered_count),
    .out_remaining_space(out_remaining_space),
    .out_total_written(out_total_written),
    .out_total_read(out_total_read),
    .out_input_closed(out_input_closed),
    .out_end_of_stream(out_end_of_stream),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity(cfg_capacity)
  );

  always #5 clk = ~clk;

  // Shadow copy of the FIFO contents and counters.
  logic [7:0]  fifo_bytes [DEPTH];
  int          fifo_head = 0;
  int          fifo_held = 0;
  bit          fifo_closed = 1'b0;
  logic [63:0] shadow_wtotal = '0;
  logic [63:0] shadow_rtotal = '0;
  int          capacity_reg = 64;

  bbf_pkg::res_t expected_status [$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;
  int            rx_wait = 0;
  bbf_pkg::res_t want_res;

  function automatic int capacity_in_force();
    return (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
  endfunction

  // Status as seen after the whole operation, also on byte transfers of a read.
  function automatic bbf_pkg::res_t status_now(bit bv, logic [7:0] b, bit acc, bit fin);
    bbf_pkg::res_t r;
    int eff;
    eff = capacity_in_force();
    r.byte_valid      = bv;
    r.out_byte        = bv ? b : 8'h00;
    r.last            = fin;
    r.write_accepted  = acc;
    r.buffered_count  = bbf_pkg::CNT_W'(fifo_held);
    r.remaining_space = (eff > fifo_held) ? bbf_pkg::CNT_W'(eff - fifo_held) : '0;
    r.total_written   = shadow_wtotal;
    r.total_read      = shadow_rtotal;
    r.input_closed    = fifo_closed;
    r.end_of_stream   = fifo_closed && (fifo_held == 0);
    return r;
  endfunction

  task automatic predict_fifo_op(input logic [2:0] op, input logic [7:0] data,
                                 input logic [6:0] len);
    int take;
    bit ok;
    logic [7:0] seen [$];
    take = (int'(len) < fifo_held) ? int'(len) : fifo_held;
    ok = 1'b0;
    if (op == bbf_pkg::OP_PEEK || op == bbf_pkg::OP_READ) begin
      for (int i = 0; i < take; i++) seen.push_back(fifo_bytes[(fifo_head + i) % DEPTH]);
    end
    if (op == bbf_pkg::OP_WRITE) begin
      ok = !fifo_closed && (fifo_held < capacity_in_force());
      if (ok) begin
        fifo_bytes[(fifo_head + fifo_held) % DEPTH] = data;
        fifo_held++;
        shadow_wtotal++;
      end
    end else if (op == bbf_pkg::OP_END) begin
      fifo_closed = 1'b1;
    end else if (op == bbf_pkg::OP_POP || op == bbf_pkg::OP_READ) begin
      fifo_head = (fifo_head + take) % DEPTH;
      fifo_held -= take;
      shadow_rtotal += take;
    end
    if (seen.size() > 0) begin
      foreach (seen[i]) expected_status.push_back(status_now(1'b1, seen[i], 1'b0,
                                                             i == seen.size() - 1));
    end else begin
      expected_status.push_back(status_now(1'b0, 8'h00, ok, 1'b1));
    end
  endtask

  // Called at a rising edge; returns at the edge of the transfer with in_valid
  // still high, so a back-to-back item keeps it up.
  task automatic send_op(input logic [2:0] op, input logic [7:0] data,
                         input logic [6:0] len);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    in_length    <= len;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_fifo_op(op, data, len);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    capacity_reg = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [6:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 7'($urandom_range(0, fifo_held));
    if (r < 16) return 7'($urandom_range(0, 8));
    return 7'($urandom_range(0, 127));
  endfunction

  // Fill bursts are mixed at random with short bursts of peeks, pops, reads and undefined codes.
  task automatic run_traffic(input int items);
    int sent;
    int burst;
    int r;
    sent = 0;
    while (sent < items) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 6) begin
        burst = $urandom_range(1, capacity_in_force() + 3);
        for (int i = 0; i < burst && sent < items; i++) begin
          send_op(bbf_pkg::OP_WRITE, 8'($urandom), 7'($urandom));
          sent++;
        end
      end else begin
        burst = $urandom_range(1, 4);
        for (int i = 0; i < burst && sent < items; i++) begin
          r = $urandom_range(0, 19);
          if (r < 6)       send_op(bbf_pkg::OP_PEEK, 8'($urandom), pick_length());
          else if (r < 11) send_op(bbf_pkg::OP_READ, 8'($urandom), pick_length());
          else if (r < 18) send_op(bbf_pkg::OP_POP, 8'($urandom), pick_length());
          else send_op(3'($urandom_range(bbf_pkg::OP_READ + 1, OP_LAST_CODE)),
                       8'($urandom), 7'($urandom));
          sent++;
        end
      end
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_directed();
    send_op(bbf_pkg::OP_PEEK, 8'h00, 7'd0);
    send_op(bbf_pkg::OP_READ, 8'hFF, 7'd64);
    send_op(bbf_pkg::OP_POP, 8'h00, 7'd127);
    send_op(bbf_pkg::OP_WRITE, 8'h00, 7'd127);
    send_op(bbf_pkg::OP_WRITE, 8'hFF, 7'd0);
    send_op(bbf_pkg::OP_WRITE, 8'hA5, 7'd64);
    send_op(bbf_pkg::OP_WRITE, 8'h5A, 7'd1);
    send_op(bbf_pkg::OP_PEEK, 8'hFF, 7'd0);
    send_op(bbf_pkg::OP_PEEK, 8'h00, 7'd2);
    send_op(bbf_pkg::OP_PEEK, 8'h00, 7'd127);
    send_op(bbf_pkg::OP_READ, 8'h00, 7'd1);
    send_op(bbf_pkg::OP_POP, 8'h00, 7'd1);
    for (int c = bbf_pkg::OP_READ + 1; c <= OP_LAST_CODE; c++) send_op(c[2:0], 8'hFF, 7'd127);
    send_op(bbf_pkg::OP_READ, 8'h00, 7'd64);
    send_op(bbf_pkg::OP_WRITE, 8'h3C, 7'd0);
    send_op(bbf_pkg::OP_READ, 8'h00, 7'd2);
  endtask

  task automatic test_capacity_limits();
    write_capacity(7'd1);
    send_op(bbf_pkg::OP_WRITE, 8'h11, 7'd0);
    send_op(bbf_pkg::OP_WRITE, 8'h22, 7'd0);
    send_op(bbf_pkg::OP_READ, 8'h00, 7'd3);
    write_capacity(7'd0);
    send_op(bbf_pkg::OP_WRITE, 8'h33, 7'd0);
    send_op(bbf_pkg::OP_PEEK, 8'h00, 7'd1);
  endtask

  task automatic test_random_traffic();
    logic [6:0] caps [7] = '{7'd64, 7'd7, 7'd1, 7'd127, 7'd0, 7'd33, 7'd2};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      run_traffic(33);
    end
  endtask

  // Held bytes stay readable after the capacity drops below them.
  task automatic test_capacity_shrink();
    write_capacity(7'd64);
    repeat (40) send_op(bbf_pkg::OP_WRITE, 8'($urandom), 7'($urandom));
    write_capacity(7'd3);
    send_op(bbf_pkg::OP_WRITE, 8'hC3, 7'd0);
    send_op(bbf_pkg::OP_READ, 8'h00, 7'd64);
    run_traffic(30);
  endtask

  task automatic test_close_input();
    write_capacity(7'd16);
    run_traffic(10);
    send_op(bbf_pkg::OP_WRITE, 8'h77, 7'd0);
    send_op(bbf_pkg::OP_END, 8'h00, 7'd0);
    send_op(bbf_pkg::OP_WRITE, 8'hEE, 7'd0);
    send_op(bbf_pkg::OP_END, 8'hFF, 7'd127);
    send_op(bbf_pkg::OP_PEEK, 8'h00, 7'd127);
    send_op(bbf_pkg::OP_READ, 8'h00, 7'd3);
    send_op(bbf_pkg::OP_POP, 8'h00, 7'd127);
    send_op(bbf_pkg::OP_READ, 8'h00, 7'd0);
    run_traffic(15);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result side: check each transfer, then draw the stall before the next one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result: expected none actual byte %0h last %0b",
                 $time, out_byte, out_last);
        mismatches++;
      end else begin
        want_res = expected_status.pop_front();
        check_field("byte_valid", want_res.byte_valid, out_byte_valid);
        check_field("out_byte", want_res.out_byte, out_byte);
        check_field("last", want_res.last, out_last);
        check_field("write_accepted", want_res.write_accepted, out_write_accepted);
        check_field("buffered_count", want_res.buffered_count, out_buffered_count);
        check_field("remaining_space", want_res.remaining_space, out_remaining_space);
        check_field("total_written", want_res.total_written, out_total_written);
        check_field("total_read", want_res.total_read, out_total_read);
        check_field("input_closed", want_res.input_closed, out_input_closed);
        check_field("end_of_stream", want_res.end_of_stream, out_end_of_stream);
      end
      rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity_limits();
    test_random_traffic();
    test_capacity_shrink();
    test_close_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> bounded_byte_stream_fifo.f
rtl/bbf_pkg.sv
rtl/bbf_ram.sv
rtl/bbf_front.sv
rtl/bbf_back.sv
rtl/bounded_byte_stream_fifo.sv
tb/sv/tb_bounded_byte_stream_fifo.sv
